FILE: rtl/number_to_text_formatter_top_defines.svh
// ----------------------------------------------------------------------------
// Number to text formatter: assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef NUMBER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH
`define NUMBER_TO_TEXT_FORMATTER_TOP_DEFINES_SVH

// same-cycle implication
`define NTF_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ntf check failed");

// next-cycle implication
`define NTF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ntf check failed");

`endif

FILE: rtl/ntf_pkg.sv
// ----------------------------------------------------------------------------
// ntf_pkg
// Types, codes and helpers of the number to text formatter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ntf_pkg;

    localparam int OUT_LIMIT        = 64;
    localparam int DEFAULT_FRAC     = 6;
    localparam int MAX_FRAC_DEF     = 10;
    localparam int NUM_SLOTS        = 7;

    localparam logic [3:0] CMD_SIGNED   = 4'd0;
    localparam logic [3:0] CMD_UNSIGNED = 4'd1;
    localparam logic [3:0] CMD_HEX      = 4'd2;
    localparam logic [3:0] CMD_HEX_UP   = 4'd3;
    localparam logic [3:0] CMD_BINARY   = 4'd4;
    localparam logic [3:0] CMD_OCTAL    = 4'd5;
    localparam logic [3:0] CMD_POINTER  = 4'd6;
    localparam logic [3:0] CMD_CHAR     = 4'd7;
    localparam logic [3:0] CMD_FIXED    = 4'd8;
    localparam logic [3:0] CMD_PERCENT  = 4'd9;

    localparam logic [2:0] SM_NONE = 3'd0;
    localparam logic [2:0] SM_HH   = 3'd1;
    localparam logic [2:0] SM_H    = 3'd2;

    localparam logic [2:0] SL_PADL = 3'd0;
    localparam logic [2:0] SL_SIGN = 3'd1;
    localparam logic [2:0] SL_ZERO = 3'd2;
    localparam logic [2:0] SL_DIG  = 3'd3;
    localparam logic [2:0] SL_DOT  = 3'd4;
    localparam logic [2:0] SL_FRAC = 3'd5;
    localparam logic [2:0] SL_PADR = 3'd6;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DEC,
        ST_POW2,
        ST_PTR,
        ST_FRAC,
        ST_SETUP,
        ST_EMIT
    } t_state;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = 8'h30 + {4'd0, d};
        end else if (upper) begin
            c = 8'h37 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

    function automatic logic [63:0] narrow(input logic [63:0] v, input logic [2:0] sm,
                                           input logic sgn);
        logic [63:0] r;
        case (sm)
            SM_NONE: r = sgn ? {{32{v[31]}}, v[31:0]} : {32'd0, v[31:0]};
            SM_HH:   r = sgn ? {{56{v[7]}}, v[7:0]} : {56'd0, v[7:0]};
            SM_H:    r = sgn ? {{48{v[15]}}, v[15:0]} : {48'd0, v[15:0]};
            default: r = v;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/number_to_text_formatter_top.sv
// ----------------------------------------------------------------------------
// number_to_text_formatter_top
// Formats one decoded printf conversion as a stream of characters.
// ----------------------------------------------------------------------------
// Input channel: i_valid / o_stall carries one conversion request per beat.
// Output channel: o_valid / i_stall carries one character per beat; o_last
// marks the final character of a conversion (1 to 64 characters).
// The block takes one request at a time and raises o_stall until the last
// character has been loaded into the output register.
// Decimal digits come from a 64-bit shift-add divide by 10 (up to 20 digits).
// Hex, octal and binary produce one digit per cycle; fixed point produces its
// fraction digits on one add-shift multiply-by-10 unit.
// Characters then leave at one per cycle while the receiver does not stall;
// a stall holds the output register and the sequencer waits.
// Reset clears the sequencer and the output valid; no request is in flight.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module number_to_text_formatter_top #(
    parameter int MAX_FRAC_DIGITS = ntf_pkg::MAX_FRAC_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire logic [3:0]         i_cmd,
    input  wire logic [63:0]        i_value,
    input  wire logic [2:0]         i_size_mod,
    input  wire logic [6:0]         i_field_width,
    input  wire logic signed [6:0]  i_precision,
    input  wire logic               i_left_align,
    input  wire logic               i_zero_pad,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output logic [7:0]              o_out_char,
    output logic                    o_last
);

    localparam int PW = $clog2(MAX_FRAC_DIGITS + 1);
    localparam int NB = ntf_pkg::OUT_LIMIT;

    ntf_pkg::t_state r_state, n_state;
    logic            r_ov, n_ov;
    logic [7:0]      r_ochar, n_ochar;
    logic            r_olast, n_olast;

    logic            r_sign, n_sign;
    logic [63:0]     r_v, n_v;
    logic [63:0]     r_q, n_q;
    logic [7:0]      r_rem, n_rem;
    logic [5:0]      r_bit, n_bit;
    logic [31:0]     r_frac, n_frac;
    logic [PW-1:0]   r_prec, n_prec;
    logic [PW-1:0]   r_fcnt, n_fcnt;
    logic            r_fix, n_fix;
    logic            r_ptr, n_ptr;
    logic [2:0]      r_shift, n_shift;
    logic            r_upper, n_upper;
    logic            r_left, n_left;
    logic            r_zp, n_zp;
    logic [6:0]      r_fw, n_fw;
    logic [7:0]      r_dbuf [NB], n_dbuf [NB];
    logic [6:0]      r_dlen, n_dlen;
    logic [3:0]      r_fbuf [MAX_FRAC_DIGITS], n_fbuf [MAX_FRAC_DIGITS];
    logic [6:0]      r_cnt [ntf_pkg::NUM_SLOTS], n_cnt [ntf_pkg::NUM_SLOTS];
    logic [2:0]      r_slot, n_slot;
    logic [6:0]      r_tot, n_tot;

    assign o_stall    = (r_state != ntf_pkg::ST_IDLE);
    assign o_valid    = r_ov;
    assign o_out_char = r_ochar;
    assign o_last     = r_olast;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ntf_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ov    <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ochar <= n_ochar;
        r_olast <= n_olast;
        r_sign  <= n_sign;
        r_v     <= n_v;
        r_q     <= n_q;
        r_rem   <= n_rem;
        r_bit   <= n_bit;
        r_frac  <= n_frac;
        r_prec  <= n_prec;
        r_fcnt  <= n_fcnt;
        r_fix   <= n_fix;
        r_ptr   <= n_ptr;
        r_shift <= n_shift;
        r_upper <= n_upper;
        r_left  <= n_left;
        r_zp    <= n_zp;
        r_fw    <= n_fw;
        r_dbuf  <= n_dbuf;
        r_dlen  <= n_dlen;
        r_fbuf  <= n_fbuf;
        r_cnt   <= n_cnt;
        r_slot  <= n_slot;
        r_tot   <= n_tot;
    end

    always_comb begin
        logic [63:0] nv;
        logic [63:0] mag;
        logic [63:0] quo;
        logic [3:0]  dig;
        logic [35:0] prod;
        logic [6:0]  len;
        logic [6:0]  wid;
        logic [6:0]  pad;
        logic [6:0]  cnt_c [ntf_pkg::NUM_SLOTS];
        logic        found;

        nv    = '0;
        mag   = '0;
        quo   = '0;
        dig   = '0;
        prod  = '0;
        len   = '0;
        wid   = '0;
        pad   = '0;
        found = 1'b0;
        for (int k = 0; k < ntf_pkg::NUM_SLOTS; k++) begin
            cnt_c[k] = '0;
        end

        n_state = r_state;
        n_ov    = r_ov;
        n_ochar = r_ochar;
        n_olast = r_olast;
        n_sign  = r_sign;
        n_v     = r_v;
        n_q     = r_q;
        n_rem   = r_rem;
        n_bit   = r_bit;
        n_frac  = r_frac;
        n_prec  = r_prec;
        n_fcnt  = r_fcnt;
        n_fix   = r_fix;
        n_ptr   = r_ptr;
        n_shift = r_shift;
        n_upper = r_upper;
        n_left  = r_left;
        n_zp    = r_zp;
        n_fw    = r_fw;
        n_dbuf  = r_dbuf;
        n_dlen  = r_dlen;
        n_fbuf  = r_fbuf;
        n_cnt   = r_cnt;
        n_slot  = r_slot;
        n_tot   = r_tot;

        if (r_ov && !i_stall) begin
            n_ov = 1'b0;
        end

        case (r_state)
            ntf_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_sign  = 1'b0;
                    n_rem   = '0;
                    n_bit   = '0;
                    n_fix   = 1'b0;
                    n_ptr   = 1'b0;
                    n_prec  = '0;
                    n_fcnt  = '0;
                    n_dlen  = '0;
                    n_upper = 1'b0;
                    n_shift = 3'd4;
                    n_left  = i_left_align;
                    n_fw    = (i_field_width > 7'(NB)) ? 7'(NB) : i_field_width;
                    n_zp    = i_zero_pad && ((i_cmd <= ntf_pkg::CMD_OCTAL)
                                             || (i_cmd == ntf_pkg::CMD_FIXED));
                    case (i_cmd)
                        ntf_pkg::CMD_SIGNED: begin
                            nv      = ntf_pkg::narrow(i_value, i_size_mod, 1'b1);
                            n_sign  = nv[63];
                            n_v     = nv[63] ? (~nv + 64'd1) : nv;
                            n_state = ntf_pkg::ST_DEC;
                        end
                        ntf_pkg::CMD_UNSIGNED: begin
                            n_v     = ntf_pkg::narrow(i_value, i_size_mod, 1'b0);
                            n_state = ntf_pkg::ST_DEC;
                        end
                        ntf_pkg::CMD_HEX, ntf_pkg::CMD_HEX_UP: begin
                            n_v     = ntf_pkg::narrow(i_value, i_size_mod, 1'b0);
                            n_upper = (i_cmd == ntf_pkg::CMD_HEX_UP);
                            n_state = ntf_pkg::ST_POW2;
                        end
                        ntf_pkg::CMD_BINARY: begin
                            n_v     = ntf_pkg::narrow(i_value, i_size_mod, 1'b0);
                            n_shift = 3'd1;
                            n_state = ntf_pkg::ST_POW2;
                        end
                        ntf_pkg::CMD_OCTAL: begin
                            n_v     = ntf_pkg::narrow(i_value, i_size_mod, 1'b0);
                            n_shift = 3'd3;
                            n_state = ntf_pkg::ST_POW2;
                        end
                        ntf_pkg::CMD_POINTER: begin
                            n_v = i_value;
                            if (i_value == 64'd0) begin
                                n_dbuf[0] = 8'h28;
                                n_dbuf[1] = 8'h6e;
                                n_dbuf[2] = 8'h69;
                                n_dbuf[3] = 8'h6c;
                                n_dbuf[4] = 8'h29;
                                n_dlen    = 7'd5;
                                n_state   = ntf_pkg::ST_SETUP;
                            end else begin
                                n_ptr   = 1'b1;
                                n_state = ntf_pkg::ST_POW2;
                            end
                        end
                        ntf_pkg::CMD_CHAR: begin
                            n_dbuf[0] = i_value[7:0];
                            n_dlen    = 7'd1;
                            n_state   = ntf_pkg::ST_SETUP;
                        end
                        ntf_pkg::CMD_FIXED: begin
                            mag    = i_value[63] ? (~i_value + 64'd1) : i_value;
                            n_sign = i_value[63];
                            n_v    = {32'd0, mag[63:32]};
                            n_frac = mag[31:0];
                            n_fix  = 1'b1;
                            if (i_precision[6]) begin
                                n_prec = PW'(ntf_pkg::DEFAULT_FRAC < MAX_FRAC_DIGITS ?
                                              ntf_pkg::DEFAULT_FRAC : MAX_FRAC_DIGITS);
                            end else if (i_precision > 7'(MAX_FRAC_DIGITS)) begin
                                n_prec = PW'(MAX_FRAC_DIGITS);
                            end else begin
                                n_prec = PW'(i_precision);
                            end
                            n_state = ntf_pkg::ST_DEC;
                        end
                        ntf_pkg::CMD_PERCENT: begin
                            n_dbuf[0] = 8'h25;
                            n_dlen    = 7'd1;
                            n_state   = ntf_pkg::ST_SETUP;
                        end
                        default: begin
                            n_dbuf[0] = 8'h25;
                            n_dbuf[1] = i_value[7:0];
                            n_dlen    = 7'd2;
                            n_state   = ntf_pkg::ST_SETUP;
                        end
                    endcase
                end
            end

            ntf_pkg::ST_DEC: begin
                // q ~ 0.8 * v by shift-add, then q / 8, then fix up the remainder
                case (r_bit)
                    6'd0: begin
                        n_q   = {1'b0, r_v[63:1]} + {2'd0, r_v[63:2]};
                        n_bit = 6'd1;
                    end
                    6'd1: begin
                        n_q   = r_q + {4'd0, r_q[63:4]};
                        n_bit = 6'd2;
                    end
                    6'd2: begin
                        n_q   = r_q + {8'd0, r_q[63:8]};
                        n_bit = 6'd3;
                    end
                    6'd3: begin
                        n_q   = r_q + {16'd0, r_q[63:16]};
                        n_bit = 6'd4;
                    end
                    6'd4: begin
                        n_q   = r_q + {32'd0, r_q[63:32]};
                        n_bit = 6'd5;
                    end
                    6'd5: begin
                        quo   = {3'd0, r_q[63:3]};
                        n_q   = quo;
                        n_rem = r_v[7:0] - {quo[4:0], 3'd0} - {quo[6:0], 1'b0};
                        n_bit = 6'd6;
                    end
                    default: begin
                        if (r_rem >= 8'd10) begin
                            n_rem = r_rem - 8'd10;
                            n_q   = r_q + 64'd1;
                        end else begin
                            for (int k = NB - 1; k > 0; k--) begin
                                n_dbuf[k] = r_dbuf[k-1];
                            end
                            n_dbuf[0] = ntf_pkg::digit_char(r_rem[3:0], 1'b0);
                            n_dlen    = r_dlen + 7'd1;
                            n_v       = r_q;
                            n_bit     = '0;
                            if (r_q == 64'd0) begin
                                if (r_fix && (r_prec != '0)) begin
                                    n_state = ntf_pkg::ST_FRAC;
                                end else begin
                                    n_state = ntf_pkg::ST_SETUP;
                                end
                            end
                        end
                    end
                endcase
            end

            ntf_pkg::ST_POW2: begin
                case (r_shift)
                    3'd1:    begin dig = {3'd0, r_v[0]};   n_v = r_v >> 1; end
                    3'd3:    begin dig = {1'b0, r_v[2:0]}; n_v = r_v >> 3; end
                    default: begin dig = r_v[3:0];         n_v = r_v >> 4; end
                endcase
                for (int k = NB - 1; k > 0; k--) begin
                    n_dbuf[k] = r_dbuf[k-1];
                end
                n_dbuf[0] = ntf_pkg::digit_char(dig, r_upper);
                n_dlen    = r_dlen + 7'd1;
                if (n_v == 64'd0) begin
                    n_state = r_ptr ? ntf_pkg::ST_PTR : ntf_pkg::ST_SETUP;
                end
            end

            ntf_pkg::ST_PTR: begin
                for (int k = NB - 1; k > 1; k--) begin
                    n_dbuf[k] = r_dbuf[k-2];
                end
                n_dbuf[0] = 8'h30;
                n_dbuf[1] = 8'h78;
                n_dlen    = r_dlen + 7'd2;
                n_state   = ntf_pkg::ST_SETUP;
            end

            ntf_pkg::ST_FRAC: begin
                prod   = {1'b0, r_frac, 3'd0} + {3'd0, r_frac, 1'b0};
                n_frac = prod[31:0];
                for (int k = MAX_FRAC_DIGITS - 1; k > 0; k--) begin
                    n_fbuf[k] = r_fbuf[k-1];
                end
                n_fbuf[0] = prod[35:32];
                n_fcnt    = r_fcnt + PW'(1);
                if (r_fcnt == PW'(MAX_FRAC_DIGITS - 1)) begin
                    n_state = ntf_pkg::ST_SETUP;
                end
            end

            ntf_pkg::ST_SETUP: begin
                len = r_dlen + {6'd0, r_sign};
                if (r_fix && (r_prec != '0)) begin
                    len = len + 7'd1 + 7'(r_prec);
                end
                wid = r_fw;
                pad = (wid > len) ? (wid - len) : 7'd0;
                cnt_c[ntf_pkg::SL_PADL] = (!r_left && !r_zp) ? pad : 7'd0;
                cnt_c[ntf_pkg::SL_SIGN] = {6'd0, r_sign};
                cnt_c[ntf_pkg::SL_ZERO] = (!r_left && r_zp) ? pad : 7'd0;
                cnt_c[ntf_pkg::SL_DIG]  = r_dlen;
                cnt_c[ntf_pkg::SL_DOT]  = (r_fix && (r_prec != '0)) ? 7'd1 : 7'd0;
                cnt_c[ntf_pkg::SL_FRAC] = r_fix ? 7'(r_prec) : 7'd0;
                cnt_c[ntf_pkg::SL_PADR] = r_left ? pad : 7'd0;
                // left-aligned: sign goes before text, pad at the end; zero pad also drops leading spaces
                if (r_left || r_zp) begin
                    cnt_c[ntf_pkg::SL_PADL] = 7'd0;
                end
                n_cnt  = cnt_c;
                n_tot  = len + pad;
                n_slot = ntf_pkg::SL_PADR;
                for (int k = 0; k < ntf_pkg::NUM_SLOTS; k++) begin
                    if (!found && (cnt_c[k] != 7'd0)) begin
                        n_slot = 3'(k);
                        found  = 1'b1;
                    end
                end
                n_state = ntf_pkg::ST_EMIT;
            end

            ntf_pkg::ST_EMIT: begin
                if (!r_ov || !i_stall) begin
                    n_ov    = 1'b1;
                    n_olast = (r_tot == 7'd1);
                    n_tot   = r_tot - 7'd1;
                    case (r_slot)
                        ntf_pkg::SL_PADL: n_ochar = 8'h20;
                        ntf_pkg::SL_SIGN: n_ochar = 8'h2d;
                        ntf_pkg::SL_ZERO: n_ochar = 8'h30;
                        ntf_pkg::SL_DIG: begin
                            n_ochar = r_dbuf[0];
                            for (int k = 0; k < NB - 1; k++) begin
                                n_dbuf[k] = r_dbuf[k+1];
                            end
                        end
                        ntf_pkg::SL_DOT:  n_ochar = 8'h2e;
                        ntf_pkg::SL_FRAC: begin
                            n_ochar = ntf_pkg::digit_char(r_fbuf[MAX_FRAC_DIGITS-1], 1'b0);
                            for (int k = MAX_FRAC_DIGITS - 1; k > 0; k--) begin
                                n_fbuf[k] = r_fbuf[k-1];
                            end
                        end
                        default:          n_ochar = 8'h20;
                    endcase
                    n_cnt[r_slot] = r_cnt[r_slot] - 7'd1;
                    if (r_cnt[r_slot] == 7'd1) begin
                        for (int k = 0; k < ntf_pkg::NUM_SLOTS; k++) begin
                            if (!found && (3'(k) > r_slot) && (r_cnt[k] != 7'd0)) begin
                                n_slot = 3'(k);
                                found  = 1'b1;
                            end
                        end
                    end
                    if (r_tot == 7'd1) begin
                        n_state = ntf_pkg::ST_IDLE;
                    end
                end
            end

            default: n_state = ntf_pkg::ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/ntf_checker.sv
// ----------------------------------------------------------------------------
// ntf_checker
// Port-level checks of the number to text formatter, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "number_to_text_formatter_top_defines.svh"

module ntf_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_valid,
    input wire logic       o_stall,
    input wire logic       o_valid,
    input wire logic       i_stall,
    input wire logic [7:0] o_out_char,
    input wire logic       o_last
);

    // stalled beat holds
    `NTF_ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall, o_valid && $stable(o_out_char) && $stable(o_last))
    // busy right after a request is taken
    `NTF_ASSERT_NEXT(a_busy, i_clk, i_rst_n, i_valid && !o_stall, o_stall)
    // a conversion streams without gaps until its last beat
    `NTF_ASSERT_NEXT(a_stream, i_clk, i_rst_n, o_valid && !i_stall && !o_last, o_valid)
    // while idle, only the last beat of the previous conversion can still wait
    `NTF_ASSERT_SAME(a_idle_last, i_clk, i_rst_n, !o_stall && o_valid, o_last)

endmodule

bind number_to_text_formatter_top ntf_checker u_ntf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_valid    (i_valid),
    .o_stall    (o_stall),
    .o_valid    (o_valid),
    .i_stall    (i_stall),
    .o_out_char (o_out_char),
    .o_last     (o_last)
);

`default_nettype wire
